// ===== sv/dsp2_pkg.sv =====
// Package: shared types and constants for the binary64 power-of-two scaler.
package dsp2_pkg;

    localparam int unsigned WordWidth  = 64;
    localparam int unsigned PowWidth   = 24;
    localparam int unsigned ExpWidth   = 11;
    localparam int unsigned FracWidth  = 52;
    localparam int unsigned MantWidth  = 53;
    // biased exponent plus power, with headroom: 24-bit power + 11-bit exponent
    localparam int unsigned BexpWidth  = 26;

    localparam logic [ExpWidth-1:0] ExpMax = 11'h7FF;

    typedef struct packed {
        logic [WordWidth-1:0] result_bits;
        logic                 range_error;
    } dsp2_out_t;

endpackage

// ===== sv/dsp2_if.sv =====
// Interfaces: input and output word channels of the scaler.
interface dsp2_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] x_bits;
    logic signed [23:0] scale_power;
    modport source (output valid, output x_bits, output scale_power, input ready);
    modport sink   (input valid, input x_bits, input scale_power, output ready);
endinterface

interface dsp2_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;
    logic        range_error;
    modport source (output valid, output result_bits, output range_error, input ready);
    modport sink   (input valid, input result_bits, input range_error, output ready);
endinterface

// ===== sv/double_scale_by_power_of_two_top.sv =====
// Top level: binary64 ldexp, four register stages, one word per cycle unless stalled.
// Takes a word every cycle while the pipe advances; each word passes the stages
// in order: decode and leading-zero count, normalize and exponent add, subnormal
// shift, round and pack. All stages advance together when the output is ready or
// empty, so a stall freezes the pipe, holds every stage and loses nothing.
module double_scale_by_power_of_two_top
    import dsp2_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dsp2_in_if.sink    in_ch,
    dsp2_out_if.source out_ch
);

    logic adv;
    logic [3:0] v_reg;

    assign adv         = out_ch.ready || !v_reg[3];
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], in_ch.valid};
    end

    // ---------- stage 1: decode, leading-zero count ----------
    logic [ExpWidth-1:0] ebits;
    logic [FracWidth-1:0] frac;
    logic pass1;
    logic [5:0] lz;

    assign ebits = in_ch.x_bits[62:52];
    assign frac  = in_ch.x_bits[51:0];
    assign pass1 = (in_ch.scale_power == '0) || (in_ch.x_bits[62:0] == '0)
                   || (ebits == ExpMax);

    always_comb
    begin
        lz = '0;
        for (int i = 0; i < FracWidth; i++)
        begin
            if (frac[i])
                lz = 6'(FracWidth - i);
        end
    end

    logic [63:0]          x1_reg;
    logic signed [23:0]   p1_reg;
    logic                 pass1_reg;
    logic [5:0]           lz1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg    <= in_ch.x_bits;
            p1_reg    <= in_ch.scale_power;
            pass1_reg <= pass1;
            lz1_reg   <= (ebits == '0) ? lz : 6'd0;
        end
    end

    // ---------- stage 2: normalize, exponent add ----------
    logic [MantWidth-1:0] m2_next;
    logic signed [BexpWidth-1:0] b2_next;

    always_comb
    begin
        if (x1_reg[62:52] == '0)
        begin
            m2_next = {1'b0, x1_reg[51:0]} << lz1_reg;
            b2_next = BexpWidth'(signed'(1)) - BexpWidth'(signed'({1'b0, lz1_reg}))
                      + BexpWidth'(p1_reg);
        end
        else
        begin
            m2_next = {1'b1, x1_reg[51:0]};
            b2_next = BexpWidth'(signed'({1'b0, x1_reg[62:52]})) + BexpWidth'(p1_reg);
        end
    end

    logic [63:0]                 x2_reg;
    logic                        pass2_reg;
    logic [MantWidth-1:0]        m2_reg;
    logic signed [BexpWidth-1:0] b2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x2_reg    <= x1_reg;
            pass2_reg <= pass1_reg;
            m2_reg    <= m2_next;
            b2_reg    <= b2_next;
        end
    end

    // ---------- stage 3: classify and subnormal shift ----------
    logic ovf3, nrm3, far3;
    logic [5:0] sh3;
    logic signed [BexpWidth-1:0] s3;
    logic [MantWidth-1:0] q3_pre;
    logic [MantWidth-1:0] rem3;
    logic [MantWidth-1:0] halfm3;

    assign ovf3 = b2_reg >= BexpWidth'(2047);
    assign nrm3 = b2_reg >= BexpWidth'(1);
    assign s3   = BexpWidth'(1) - b2_reg;
    assign far3 = s3 > BexpWidth'(53);
    assign sh3  = far3 ? 6'd53 : s3[5:0];

    always_comb
    begin
        q3_pre = m2_reg >> sh3;
        rem3   = m2_reg & ((MantWidth'(1) << sh3) - MantWidth'(1));
        halfm3 = (sh3 == '0) ? '0 : (MantWidth'(1) << (sh3 - 6'd1));
    end

    logic [63:0]          x3_reg;
    logic                 pass3_reg, ovf3_reg, nrm3_reg, far3_reg;
    logic [ExpWidth-1:0]  e3_reg;
    logic [FracWidth-1:0] f3_reg;
    logic [MantWidth-1:0] q3_reg;
    logic                 gt3_reg, eq3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x3_reg    <= x2_reg;
            pass3_reg <= pass2_reg;
            ovf3_reg  <= ovf3;
            nrm3_reg  <= nrm3;
            far3_reg  <= far3;
            e3_reg    <= b2_reg[ExpWidth-1:0];
            f3_reg    <= m2_reg[FracWidth-1:0];
            q3_reg    <= q3_pre;
            gt3_reg   <= rem3 > halfm3;
            eq3_reg   <= rem3 == halfm3;
        end
    end

    // ---------- stage 4: round and pack ----------
    dsp2_out_t o_next;
    logic [MantWidth-1:0] qr;

    always_comb
    begin
        qr = '0;
        o_next.result_bits = x3_reg;
        o_next.range_error = 1'b0;
        if (!pass3_reg)
        begin
            if (ovf3_reg)
            begin
                o_next.result_bits = {x3_reg[63], ExpMax, 52'd0};
                o_next.range_error = 1'b1;
            end
            else if (nrm3_reg)
                o_next.result_bits = {x3_reg[63], e3_reg, f3_reg};
            else
            begin
                if (!far3_reg)
                    qr = q3_reg + MantWidth'(gt3_reg || (eq3_reg && q3_reg[0]));
                o_next.result_bits = {x3_reg[63], 10'd0, qr};
                o_next.range_error = (qr == '0);
            end
        end
    end

    dsp2_out_t o_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            o_reg <= o_next;
    end

    assign out_ch.valid       = v_reg[3];
    assign out_ch.result_bits = o_reg.result_bits;
    assign out_ch.range_error = o_reg.range_error;

    // a stalled output holds its word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.result_bits))
        else $error("output word changed under stall");
    // a range error always gives zero or infinity
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] && o_reg.range_error |-> o_reg.result_bits[62:0] == '0
            || o_reg.result_bits[62:0] == {ExpMax, 52'd0})
        else $error("range flag on a finite nonzero result");
    // pipe advances whenever the output side is free
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[3] |-> in_ch.ready)
        else $error("pipe stalled with empty output");

endmodule
